// File: hdl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// shared types, constants and the magnitude compare for the 2:4 prune/pack
// ----------------------------------------------------------------------------
`default_nettype none

package tpp_pkg;

   localparam int unsigned ELEMENT_BITS = 32;
   localparam int unsigned GROUP_SIZE   = 4;
   localparam int unsigned POS_BITS     = $clog2(GROUP_SIZE);
   localparam int unsigned MAG_BITS     = ELEMENT_BITS - 1;

   // magnitude of +infinity; anything above it is a nan
   localparam logic [MAG_BITS-1:0] INF_MAG = MAG_BITS'(32'h7F80_0000);

   typedef logic [ELEMENT_BITS-1:0] word_type;
   typedef logic [POS_BITS-1:0]     pos_type;

   typedef struct packed {
      word_type value_0;
      word_type value_1;
      word_type value_2;
      word_type value_3;
      logic     last_in;
   } req_type;

   typedef struct packed {
      logic [GROUP_SIZE-1:0] keep_mask;
      word_type              first_kept;
      word_type              second_kept;
      logic                  last_out;
   } rsp_type;

   // one network entry: group position and the raw word found there
   typedef struct packed {
      pos_type  pos;
      word_type word;
   } lane_type;

   typedef struct packed {
      lane_type [GROUP_SIZE-1:0] lanes;
      logic                      last;
   } work_type;

   // true when |a| > |b|; any compare with a nan is false
   function automatic logic mag_greater(input word_type a, input word_type b);
      logic [MAG_BITS-1:0] ma;
      logic [MAG_BITS-1:0] mb;
      ma = a[MAG_BITS-1:0];
      mb = b[MAG_BITS-1:0];
      if ((ma > INF_MAG) || (mb > INF_MAG)) begin
         return 1'b0;
      end
      return ma > mb;
   endfunction

endpackage

`default_nettype wire

// File: hdl/tpp_cas_stage.sv
// ----------------------------------------------------------------------------
// tpp_cas_stage
// one pipeline stage of the compare network: two compare-and-swaps in order
// ----------------------------------------------------------------------------
`default_nettype none

module tpp_cas_stage #(
   parameter logic [1:0] I0 = 2'd0,
   parameter logic [1:0] J0 = 2'd1,
   parameter logic [1:0] I1 = 2'd0,
   parameter logic [1:0] J1 = 2'd2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tpp_pkg::work_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output tpp_pkg::work_type      out_data
);
   import tpp_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   work_type data_ff;
   work_type data_in;
   lane_type tmp;
   logic [GROUP_SIZE-1:0] seen;

   always_comb begin
      data_in = in_data;
      tmp     = data_in.lanes[I0];
      if (mag_greater(data_in.lanes[I0].word, data_in.lanes[J0].word)) begin
         data_in.lanes[I0] = data_in.lanes[J0];
         data_in.lanes[J0] = tmp;
      end
      tmp = data_in.lanes[I1];
      if (mag_greater(data_in.lanes[I1].word, data_in.lanes[J1].word)) begin
         data_in.lanes[I1] = data_in.lanes[J1];
         data_in.lanes[J1] = tmp;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // positions held in the stage must stay a permutation of the group
   always_comb begin
      seen = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
         seen[data_ff.lanes[k].pos] = 1'b1;
      end
   end

   a_permutation: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (seen == {GROUP_SIZE{1'b1}}))
      else $error("stage lost or duplicated a group position");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> (valid_ff && $stable(data_ff)))
      else $error("stalled stage changed its transaction");

endmodule

`default_nettype wire

// File: hdl/tpp_pack_stage.sv
// ----------------------------------------------------------------------------
// tpp_pack_stage
// turns the two winning entries into the keep mask and ordered kept words
// ----------------------------------------------------------------------------
`default_nettype none

module tpp_pack_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tpp_pkg::work_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output tpp_pkg::rsp_type       out_data
);
   import tpp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;
   pos_type pos_a;
   pos_type pos_b;

   always_comb begin
      pos_a = in_data.lanes[2].pos;
      pos_b = in_data.lanes[3].pos;
      data_in.keep_mask = (GROUP_SIZE'(1) << pos_a) | (GROUP_SIZE'(1) << pos_b);
      // kept words leave in group position order
      if (pos_a < pos_b) begin
         data_in.first_kept  = in_data.lanes[2].word;
         data_in.second_kept = in_data.lanes[3].word;
      end else begin
         data_in.first_kept  = in_data.lanes[3].word;
         data_in.second_kept = in_data.lanes[2].word;
      end
      data_in.last_out = in_data.last;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_two_kept: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ($countones(data_ff.keep_mask) == 2))
      else $error("keep mask does not hold exactly two positions");

endmodule

`default_nettype wire

// File: hdl/two_of_four_prune_pack.sv
// ----------------------------------------------------------------------------
// two_of_four_prune_pack
// 2:4 structured-sparsity pruning of groups of four single-precision words
// ----------------------------------------------------------------------------
// Takes one group of four raw float words per transaction and returns the
// keep mask and the two words of largest magnitude (sign ignored, nan never
// wins a compare), lower group position first, with the last flag carried
// along. One group is accepted every cycle unless backpressure holds the
// pipeline; rsp_valid for a group rises once it has passed the three compare
// stage registers and the pack register. The six compare-and-swaps of the
// ranking network run two per stage over three stages, and a fourth stage
// builds the mask and the output register. Backpressure stalls the whole
// pipeline without losing or repeating a transaction.
`default_nettype none

module two_of_four_prune_pack (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tpp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tpp_pkg::rsp_type      rsp_data
);
   import tpp_pkg::*;

   work_type entry;
   work_type s1_data;
   work_type s2_data;
   work_type s3_data;
   logic     s1_valid;
   logic     s1_ready;
   logic     s2_valid;
   logic     s2_ready;
   logic     s3_valid;
   logic     s3_ready;

   always_comb begin
      entry.lanes[0] = '{pos: pos_type'(0), word: req_data.value_0};
      entry.lanes[1] = '{pos: pos_type'(1), word: req_data.value_1};
      entry.lanes[2] = '{pos: pos_type'(2), word: req_data.value_2};
      entry.lanes[3] = '{pos: pos_type'(3), word: req_data.value_3};
      entry.last     = req_data.last_in;
   end

   tpp_cas_stage #(.I0(2'd0), .J0(2'd1), .I1(2'd0), .J1(2'd2)) u_stage1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (entry),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   tpp_cas_stage #(.I0(2'd0), .J0(2'd3), .I1(2'd1), .J1(2'd2)) u_stage2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   tpp_cas_stage #(.I0(2'd1), .J0(2'd3), .I1(2'd2), .J1(2'd3)) u_stage3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   tpp_pack_stage u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for two_of_four_prune_pack
// ----------------------------------------------------------------------------
// An initial block queues a short directed set of groups: extremes, ties,
// signed zeros, infinities, nans at every position and subnormals. It then
// queues random groups drawn from the same value classes, some of them with
// forced ties. A clocked driver sends the queue with random gaps. A clocked
// monitor predicts the keep mask and the kept words of every accepted group
// and checks each result against the oldest prediction. The result side
// stalls at random as well.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tpp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned RANDOM_GROUPS = 1150;
   // magnitude of infinity; a larger magnitude is a nan
   localparam logic [30:0] INF_MAGNITUDE = 31'h7F80_0000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type     group_q[$];
   rsp_type     pruned_q[$];
   logic        req_taken = 1'b0;
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned recv_calm = 0;
   int unsigned ready_hold = 0;
   int unsigned cycles = 0;
   int unsigned errors = 0;

   two_of_four_prune_pack dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // |a| > |b| with the sign ignored; a nan on either side never wins
   function automatic logic outranks(input word_type a, input word_type b);
      if ((a[30:0] > INF_MAGNITUDE) || (b[30:0] > INF_MAGNITUDE)) begin
         return 1'b0;
      end
      return a[30:0] > b[30:0];
   endfunction

   function automatic rsp_type prune_group(input req_type g);
      word_type w[4];
      pos_type  order[4];
      pos_type  t;
      pos_type  lo;
      pos_type  hi;
      rsp_type  r;
      w[0] = g.value_0;
      w[1] = g.value_1;
      w[2] = g.value_2;
      w[3] = g.value_3;
      for (int i = 0; i < 4; i++) begin
         order[i] = pos_type'(i);
      end
      // fixed compare-and-swap network; the two largest end in entries 2 and 3
      for (int i = 0; i < 3; i++) begin
         for (int j = i + 1; j < 4; j++) begin
            if (outranks(w[order[i]], w[order[j]])) begin
               t = order[i];
               order[i] = order[j];
               order[j] = t;
            end
         end
      end
      lo = order[2];
      hi = order[3];
      if (lo > hi) begin
         t = lo;
         lo = hi;
         hi = t;
      end
      r.keep_mask = '0;
      r.keep_mask[lo] = 1'b1;
      r.keep_mask[hi] = 1'b1;
      r.first_kept = w[lo];
      r.second_kept = w[hi];
      r.last_out = g.last_in;
      return r;
   endfunction

   function automatic word_type pick_word();
      word_type    w;
      int unsigned r;
      w = $urandom();
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return w;
      end
      if (r < 52) begin
         return {w[31], 8'hFF, (w[22:0] == 23'h0) ? 23'h1 : w[22:0]};
      end
      if (r < 60) begin
         return {w[31], INF_MAGNITUDE};
      end
      if (r < 68) begin
         return {w[31], 31'h0};
      end
      if (r < 78) begin
         return {w[31], 8'h00, w[22:0]};
      end
      if (r < 90) begin
         // narrow spread near 1.0 so that ties turn up often
         return {w[31], 8'h7F, 20'h0, w[2:0]};
      end
      return {w[31], w[0] ? 31'h7F7F_FFFF : 31'h7F80_0001};
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic add_group(input word_type a, input word_type b, input word_type c,
                            input word_type d, input logic last);
      req_type g;
      g.value_0 = a;
      g.value_1 = b;
      g.value_2 = c;
      g.value_3 = d;
      g.last_in = last;
      group_q.push_back(g);
   endtask

   // stretches with no idling on either side
   always @(negedge clock) begin
      send_calm <= (send_calm > 0) ? send_calm - 1 :
                   (($urandom_range(0, 299) == 0) ? $urandom_range(30, 150) : 0);
      recv_calm <= (recv_calm > 0) ? recv_calm - 1 :
                   (($urandom_range(0, 299) == 0) ? $urandom_range(30, 150) : 0);
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the transaction until it is taken
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (group_q.size() > 0) begin
         req_data <= group_q.pop_front();
         req_valid <= 1'b1;
         send_gap <= (send_calm > 0) ? 0 : pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result-side backpressure
   always @(negedge clock) begin : ready_drive
      int unsigned stall;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready) begin
         stall = (recv_calm > 0) ? 0 : pick_gap();
         if (stall == 0) begin
            ready_hold <= $urandom_range(0, 15);
         end else begin
            rsp_ready <= 1'b0;
            ready_hold <= stall - 1;
         end
      end else begin
         rsp_ready <= 1'b1;
         ready_hold <= $urandom_range(0, 15);
      end
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            pruned_q.push_back(prune_group(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (pruned_q.size() == 0) begin
               $display("%0t unexpected result: mask %h first %h second %h last %b", $realtime,
                        rsp_data.keep_mask, rsp_data.first_kept, rsp_data.second_kept,
                        rsp_data.last_out);
               errors = errors + 1;
            end else begin
               want = pruned_q.pop_front();
               if (rsp_data.keep_mask !== want.keep_mask) begin
                  $display("%0t keep_mask expected %h actual %h", $realtime,
                           want.keep_mask, rsp_data.keep_mask);
                  errors = errors + 1;
               end
               if (rsp_data.first_kept !== want.first_kept) begin
                  $display("%0t first_kept expected %h actual %h", $realtime,
                           want.first_kept, rsp_data.first_kept);
                  errors = errors + 1;
               end
               if (rsp_data.second_kept !== want.second_kept) begin
                  $display("%0t second_kept expected %h actual %h", $realtime,
                           want.second_kept, rsp_data.second_kept);
                  errors = errors + 1;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $display("%0t last_out expected %b actual %b", $realtime,
                           want.last_out, rsp_data.last_out);
                  errors = errors + 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      word_type    w[4];
      int unsigned src;
      int unsigned dst;

      // extremes and bit patterns
      add_group(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_group(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_group(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      add_group(32'hAAAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA, 32'hD555_5555, 1'b1);
      // ordered, reversed and mixed signs
      add_group(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 1'b0);
      add_group(32'h4080_0000, 32'h4040_0000, 32'h4000_0000, 32'h3F80_0000, 1'b0);
      add_group(32'hC080_0000, 32'h3F80_0000, 32'hC040_0000, 32'h4000_0000, 1'b1);
      add_group(32'h4000_0000, 32'hC080_0000, 32'h3F80_0000, 32'hC040_0000, 1'b0);
      // signed zeros and ties
      add_group(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0);
      add_group(32'h40A0_0000, 32'h40A0_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      add_group(32'h3F80_0000, 32'hC0A0_0000, 32'h40A0_0000, 32'h3F80_0000, 1'b1);
      add_group(32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 1'b0);
      // infinities, largest finite, nan boundary
      add_group(32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h3F80_0000, 1'b0);
      add_group(32'h7F80_0001, 32'h7F80_0000, 32'h0000_0001, 32'hFF7F_FFFF, 1'b1);
      // a nan at each position
      add_group(32'h7FC0_0000, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 1'b0);
      add_group(32'h3F80_0000, 32'hFFC0_0001, 32'h4000_0000, 32'h4040_0000, 1'b0);
      add_group(32'h3F80_0000, 32'h4000_0000, 32'h7FFF_FFFF, 32'h4040_0000, 1'b1);
      add_group(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h7F80_0001, 1'b0);
      add_group(32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000, 1'b0);
      add_group(32'h4080_0000, 32'h7FC0_0000, 32'h3F80_0000, 32'h7FC0_0000, 1'b1);
      // subnormals
      add_group(32'h0000_0001, 32'h0000_0002, 32'h0000_0000, 32'h807F_FFFF, 1'b0);
      add_group(32'h007F_FFFF, 32'h8000_0001, 32'h0080_0000, 32'h0000_0000, 1'b1);

      for (int n = 0; n < RANDOM_GROUPS; n++) begin
         for (int k = 0; k < 4; k++) begin
            w[k] = pick_word();
         end
         // copy one magnitude onto another position for a tie
         if ($urandom_range(0, 3) == 0) begin
            src = $urandom_range(0, 3);
            dst = $urandom_range(0, 3);
            w[dst] = {1'($urandom_range(0, 1)), w[src][30:0]};
         end
         add_group(w[0], w[1], w[2], w[3], 1'($urandom_range(0, 1)));
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (group_q.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (pruned_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
